### hw/rtl/sfd_pkg.sv
package sfd_pkg;

    // fixed field widths
    localparam int SAMPLE_W  = 12;
    localparam int COEF_W    = 16;
    localparam int PAIR_W    = SAMPLE_W + 1;
    localparam int PROD_W    = COEF_W + PAIR_W + 1;
    localparam int PSUM_W    = PROD_W + 1;
    localparam int SUM_W     = 32;
    localparam int SLOT_W    = 5;
    localparam int DECIM_W   = 8;
    localparam int CFG_IDX_W = 4;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 40;

    // coefficient slots: five pairs and the center tap
    localparam int NUM_COEFS = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DECIM       = 4'd6;

    localparam logic [DECIM_W-1:0] DECIM_RESET = 8'd10;

    typedef logic [NUM_COEFS-1:0][COEF_W-1:0] t_coef_vec;
    typedef logic [NUM_COEFS-1:0][PAIR_W-1:0] t_pair_vec;

endpackage

### hw/rtl/sfd_mac.sv
module sfd_mac
    import sfd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_pair_vec         i_pair,
    input  logic [SLOT_W-1:0] i_slot,
    input  t_coef_vec         i_coef,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [SUM_W-1:0]  o_filtered,
    output logic [SLOT_W-1:0] o_slot
);

    logic                     r_b_valid;
    logic signed [PROD_W-1:0] r_b_prod [NUM_COEFS];
    logic [SLOT_W-1:0]        r_b_slot;
    logic                     r_c_valid;
    logic signed [PSUM_W-1:0] r_c_sum [NUM_COEFS/2];
    logic [SLOT_W-1:0]        r_c_slot;
    logic                     r_o_valid;
    logic [SUM_W-1:0]         r_o_sum;
    logic [SLOT_W-1:0]        r_o_slot;
    logic                     adv_b;
    logic                     adv_c;
    logic                     adv_o;
    logic signed [SUM_W-1:0]  n_o_sum;

    // each stage moves when it is empty or the next one moves
    assign adv_o   = !r_o_valid || i_ready;
    assign adv_c   = !r_c_valid || adv_o;
    assign adv_b   = !r_b_valid || adv_c;
    assign o_ready = adv_b;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv_b) r_b_valid <= i_valid;
            if (adv_c) r_c_valid <= r_b_valid;
            if (adv_o) r_o_valid <= r_c_valid;
        end
    end

    // products of coefficient and pair sum
    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_b_prod[k] <= $signed(i_coef[k]) * $signed({1'b0, i_pair[k]});
            end
            r_b_slot <= i_slot;
        end
    end

    // first adder level
    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            for (int k = 0; k < NUM_COEFS/2; k++) begin
                r_c_sum[k] <= PSUM_W'(r_b_prod[2*k]) + PSUM_W'(r_b_prod[2*k+1]);
            end
            r_c_slot <= r_b_slot;
        end
    end

    // final sum into the result register
    always_comb begin
        n_o_sum = '0;
        for (int k = 0; k < NUM_COEFS/2; k++) begin
            n_o_sum = n_o_sum + SUM_W'(r_c_sum[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_o && r_c_valid) begin
            r_o_sum  <= n_o_sum;
            r_o_slot <= r_c_slot;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_filtered = r_o_sum;
    assign o_slot     = r_o_slot;

endmodule

### hw/rtl/symmetric_fir_decimator_unit.sv
// Symmetric FIR decimator: each input item is one unsigned 12-bit converter
// code that is shifted into a TAP_COUNT-deep delay line. The block forms the
// linear-phase sum of the symmetric pairs and the center tap with signed
// Q1.15 coefficients (registers 0..5) and keeps one filtered value out of
// every decimation_factor (register 6, zero acts as one). A kept value leaves
// as a 32-bit signed sum with its slot in a RING_DEPTH-entry ring, slot in
// bits 36:32 of m_axis_tdata. One item is accepted per cycle unless the
// pipeline is stalled; a kept value passes through a pair-add, multiply and two
// adder stages, each of which holds while the output waits. Configuration is
// taken every cycle and should only be written while the block is idle.
module symmetric_fir_decimator_unit
    import sfd_pkg::*;
#(
    parameter int TAP_COUNT  = 11,
    parameter int RING_DEPTH = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_W-1:0]      s_axis_tdata,   // [11:0] sample
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [OUT_W-1:0]     m_axis_tdata,   // [31:0] filtered, [36:32] ring_slot
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    localparam int NUM_PAIRS = TAP_COUNT / 2;
    localparam int CENTER    = TAP_COUNT / 2;

    logic [SAMPLE_W-1:0] r_delay [TAP_COUNT];
    logic [SAMPLE_W-1:0] n_delay [TAP_COUNT];
    t_coef_vec           r_coef;
    logic [DECIM_W-1:0]  r_decim;
    logic [DECIM_W-1:0]  r_count;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_a_valid;
    t_pair_vec           r_a_pair;
    t_pair_vec           n_a_pair;
    logic [SLOT_W-1:0]   r_a_slot;
    logic                mac_ready;
    logic                in_acc;
    logic                keep;
    logic [DECIM_W-1:0]  factor;
    logic [SUM_W-1:0]    out_sum;
    logic [SLOT_W-1:0]   out_slot;

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_a_valid || mac_ready;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef  <= '0;
            r_decim <= DECIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index <= REG_COEF_CENTER) begin
                r_coef[i_cfg_index[$clog2(NUM_COEFS)-1:0]] <= i_cfg_data;
            end else if (i_cfg_index == REG_DECIM) begin
                r_decim <= i_cfg_data[DECIM_W-1:0];
            end
        end
    end

    // delay line after the incoming sample is shifted in
    always_comb begin
        n_delay[0] = s_axis_tdata[SAMPLE_W-1:0];
        for (int k = 1; k < TAP_COUNT; k++) begin
            n_delay[k] = r_delay[k-1];
        end
    end

    // symmetric pair sums, center tap in the last slot
    always_comb begin
        for (int k = 0; k < NUM_COEFS; k++) begin
            n_a_pair[k] = '0;
            if (k < NUM_PAIRS && k < NUM_COEFS - 1) begin
                n_a_pair[k] = PAIR_W'(n_delay[k]) + PAIR_W'(n_delay[TAP_COUNT-1-k]);
            end else if (k == NUM_COEFS - 1 && (TAP_COUNT % 2) == 1) begin
                n_a_pair[k] = PAIR_W'(n_delay[CENTER]);
            end
        end
    end

    // decimation decision
    assign factor = (r_decim == '0) ? DECIM_W'(1) : r_decim;
    assign keep   = ({1'b0, r_count} + 9'd1) >= {1'b0, factor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                r_delay[k] <= '0;
            end
            r_count <= '0;
            r_slot  <= '0;
        end else if (in_acc) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                r_delay[k] <= n_delay[k];
            end
            if (keep) begin
                r_count <= '0;
                if (({1'b0, r_slot} + 6'd1) >= 6'(RING_DEPTH)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end else begin
                r_count <= r_count + DECIM_W'(1);
            end
        end
    end

    // input stage: only kept items go on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= in_acc && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && keep) begin
            r_a_pair <= n_a_pair;
            r_a_slot <= r_slot;
        end
    end

    sfd_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_a_valid),
        .o_ready    (mac_ready),
        .i_pair     (r_a_pair),
        .i_slot     (r_a_slot),
        .i_coef     (r_coef),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_filtered (out_sum),
        .o_slot     (out_slot)
    );

    assign m_axis_tdata = {(OUT_W - SUM_W - SLOT_W)'(0), out_slot, out_sum};

    // checks
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, m_axis_tdata[36:32]} < 6'(RING_DEPTH)))
        else $error("ring slot out of range");

    a_drop_holds_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !keep) |=> $stable(r_slot))
        else $error("dropped item moved the ring slot");

    a_keep_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && keep) |=> (r_count == '0) && r_a_valid)
        else $error("kept item did not enter the pipeline");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

### bench/symmetric_fir_decimator_unit_tb.sv
`timescale 1ns / 100ps

module symmetric_fir_decimator_unit_tb;
    import sfd_pkg::*;

    localparam int TAPS       = 11;
    localparam int RING_SLOTS = 20;
    localparam int SETTLE     = 8;
    localparam int HOLD_LEN   = 300;
    localparam int RAND_ITEMS = 1050;

    // register index of the first pair weight, pair k is at this plus k
    localparam logic [CFG_IDX_W-1:0] REG_COEF_OUTER0 = 4'd0;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    typedef struct packed {
        logic signed [31:0] filtered;
        logic [SLOT_W-1:0]  slot;
    } t_fir_out;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata  = '0;   // [11:0] sample
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;         // [31:0] filtered, [36:32] ring_slot
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [COEF_W-1:0]    i_cfg_data    = '0;

    // filter state mirrored for prediction
    logic [SAMPLE_W-1:0]       tap_line [TAPS];
    logic signed [COEF_W-1:0]  coef_reg [NUM_COEFS];
    logic [DECIM_W-1:0]        decim_factor;
    logic [DECIM_W-1:0]        drop_count;
    logic [SLOT_W-1:0]         ring_pos;

    t_fir_out kept_q [$];
    t_fir_out want_out;
    int       err_count   = 0;
    int       burst_left  = 0;
    bit       hold_request = 1'b0;
    bit       hold_started = 1'b0;
    int       hold_left   = 0;
    int       rx_left     = 0;
    int       rx_phase    = 0;
    t_rx_mode rx_mode     = RX_ALWAYS;

    symmetric_fir_decimator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard limit on the run
    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic clear_filter_state();
        for (int k = 0; k < TAPS; k++) tap_line[k] = '0;
        for (int k = 0; k < NUM_COEFS; k++) coef_reg[k] = '0;
        decim_factor = DECIM_RESET;
        drop_count   = '0;
        ring_pos     = '0;
    endtask

    // shift one sample in, form the symmetric sum and decide whether it is kept
    task automatic filter_sample(input logic [SAMPLE_W-1:0] smp);
        longint   acc;
        int       eff;
        t_fir_out res;
        acc = 0;
        for (int k = TAPS - 1; k >= 1; k--) tap_line[k] = tap_line[k-1];
        tap_line[0] = smp;
        for (int k = 0; k < TAPS / 2; k++)
            acc += longint'(coef_reg[k]) *
                   longint'(int'(tap_line[k]) + int'(tap_line[TAPS-1-k]));
        acc += longint'(coef_reg[REG_COEF_CENTER[$clog2(NUM_COEFS)-1:0]]) *
               longint'(int'(tap_line[TAPS/2]));
        eff = (decim_factor == 0) ? 1 : int'(decim_factor);
        if (int'(drop_count) + 1 >= eff) begin
            drop_count   = '0;
            res.filtered = acc[31:0];
            res.slot     = ring_pos;
            kept_q.push_back(res);
            if (int'(ring_pos) + 1 >= RING_SLOTS) ring_pos = '0;
            else ring_pos = ring_pos + 1'b1;
        end else begin
            drop_count = drop_count + 1'b1;
        end
    endtask

    // one register write, applied to the mirror at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_COEFS) coef_reg[idx[$clog2(NUM_COEFS)-1:0]] = val;
        else if (idx == REG_DECIM) decim_factor = val[DECIM_W-1:0];
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // one sample item, sent in bursts with random gaps in between
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_W-SAMPLE_W){1'b0}}, smp};
        do @(posedge i_clk); while (!s_axis_tready);
        filter_sample(smp);
    endtask

    // stop sending, let every expected item come out and the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // reset state: zero weights, keep one of ten
    task automatic test_reset_defaults();
        repeat (10) send_sample('1);
        wait_idle();
    endtask

    // largest positive weights, every value kept
    task automatic test_coef_extremes();
        for (int k = 0; k < NUM_COEFS; k++)
            write_reg(REG_COEF_OUTER0 + CFG_IDX_W'(k), 16'h7FFF);
        write_reg(REG_DECIM, 16'd1);
        send_sample('0);
        send_sample('1);
        send_sample('1);
        wait_idle();
    endtask

    // most negative weights, factor zero acts as one
    task automatic test_zero_factor();
        for (int k = 0; k < NUM_COEFS; k++)
            write_reg(REG_COEF_OUTER0 + CFG_IDX_W'(k), 16'h8000);
        write_reg(REG_DECIM, 16'd0);
        send_sample('1);
        send_sample('1);
        wait_idle();
    endtask

    // unused indexes are ignored, upper bits of the factor are dropped
    task automatic test_register_decode();
        for (int k = 0; k < NUM_COEFS; k++)
            write_reg(REG_COEF_OUTER0 + CFG_IDX_W'(k), pick_coef());
        for (int i = REG_DECIM + 1; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), COEF_W'($urandom));
        write_reg(REG_DECIM, 16'hFF03);
        repeat (3) send_sample(pick_sample());
        wait_idle();
    endtask

    // factor lowered below the drop count keeps the next value at once
    task automatic test_factor_lowered();
        write_reg(REG_DECIM, 16'd10);
        repeat (5) send_sample(pick_sample());
        wait_idle();
        write_reg(REG_DECIM, 16'd2);
        send_sample(pick_sample());
        wait_idle();
    endtask

    // long output stall while the sender keeps going, so the input backs up
    task automatic test_stall_fill();
        write_reg(REG_DECIM, 16'd1);
        hold_request = 1'b1;
        repeat (40) send_sample(pick_sample());
        wait_idle();
    endtask

    // random weights and factors per phase, random samples in between
    task automatic test_random_phases();
        int items;
        int phase_len;
        logic [DECIM_W-1:0] fac;
        items = 0;
        while (items < RAND_ITEMS) begin
            wait_idle();
            for (int k = 0; k < NUM_COEFS; k++)
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_COEF_OUTER0 + CFG_IDX_W'(k), pick_coef());
            case ($urandom_range(0, 19))
                0, 1:    fac = DECIM_W'($urandom_range(0, 1));
                2:       fac = 8'd255;
                3, 4, 5: fac = DECIM_W'($urandom_range(7, 24));
                default: fac = DECIM_W'($urandom_range(2, 6));
            endcase
            write_reg(REG_DECIM, {DECIM_W'($urandom), fac});
            phase_len = (fac >= 100) ? 300 : $urandom_range(30, 90);
            repeat (phase_len) send_sample(pick_sample());
            items += phase_len;
        end
        wait_idle();
    endtask

    // receiver: stalls on its own pattern, or holds off for a long stretch
    always @(posedge i_clk) begin
        rx_phase++;
        if (hold_request && !hold_started) begin
            hold_left = HOLD_LEN;
            hold_started = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 96);
            end
            rx_left--;
            case (rx_mode)
                RX_ALWAYS:   m_axis_tready <= 1'b1;
                RX_COIN:     m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_axis_tready <= ($urandom_range(0, 7) != 0);
                default:     m_axis_tready <= ((rx_phase % 5) >= 2);
            endcase
        end
    end

    // compare each output item with the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (kept_q.size() == 0) begin
                report_mismatch("unexpected item, filtered",
                                longint'($signed(m_axis_tdata[31:0])), 0);
            end else begin
                want_out = kept_q.pop_front();
                if (m_axis_tdata[31:0] !== want_out.filtered)
                    report_mismatch("filtered", longint'($signed(m_axis_tdata[31:0])),
                                    longint'(want_out.filtered));
                if (m_axis_tdata[32 +: SLOT_W] !== want_out.slot)
                    report_mismatch("ring_slot", longint'(m_axis_tdata[32 +: SLOT_W]),
                                    longint'(want_out.slot));
            end
        end
    end

    // test sequence
    initial begin
        int guard;
        clear_filter_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_coef_extremes();
        test_zero_factor();
        test_register_decode();
        test_factor_lowered();
        test_stall_fill();
        test_random_phases();

        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (kept_q.size() != 0 && guard < 4000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (kept_q.size() != 0)
            report_mismatch("items never delivered", kept_q.size(), 0);

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
